### src/scs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for sparse cosine similarity
// Accumulator widths, result widths and controller/datapath command structs.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int ELEM_W       = 16;
    localparam int ACC_W        = 48;
    localparam int COS_W        = 16;
    localparam int PROD_W       = 96;
    localparam int CMP_W        = 128;
    localparam int QBITS        = 15;
    localparam int MAX_ELEMENTS = 65536;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [COS_W-1:0] COS_ONE = 16'd32768;

    typedef struct packed {
        logic accum;     // add the accepted pair into the accumulators
        logic clear;     // zero the accumulators
        logic start;     // latch accumulators and begin the root/divide search
        logic step;      // run one step of the search sequence
        logic load_out;  // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic search_done;
    } stat_t;

endpackage

### src/scs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_datapath: accumulators and sequential root/divide search
// Saturating accumulation of dot and square sums, then a bit search for
// q with prod*q^2 <= 2^30*dot^2, using one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module scs_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  scs_pkg::cmd_t                    cmd,
    output scs_pkg::stat_t                   stat,
    input  logic [scs_pkg::ELEM_W-1:0]       elem_a,
    input  logic [scs_pkg::ELEM_W-1:0]       elem_b,
    output logic [scs_pkg::COS_W-1:0]        cos_val,
    output logic                             ovl_flag
);

    localparam int AW = scs_pkg::ACC_W;
    localparam int EW = scs_pkg::ELEM_W;
    localparam int PW = scs_pkg::PROD_W;
    localparam int CW = scs_pkg::CMP_W;

    // micro-sequence phases of the multiply engine
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_SQ    = 4'd1;  // dot^2 partials
    localparam logic [3:0] PH_PR    = 4'd2;  // sa*sb partials
    localparam logic [3:0] PH_TT    = 4'd3;  // t*t
    localparam logic [3:0] PH_PT    = 4'd4;  // prod*t2 partials
    localparam logic [3:0] PH_CMP   = 4'd5;
    localparam logic [3:0] PH_DONE  = 4'd6;

    logic [AW-1:0] dot_reg, sa_reg, sb_reg;
    logic [AW-1:0] dot_next, sa_next, sb_next;

    logic [2*EW-1:0] p_ab, p_aa, p_bb;
    logic [AW:0]     s_ab, s_aa, s_bb;
    logic            nz;

    assign nz   = (elem_a != '0) && (elem_b != '0);
    assign p_ab = elem_a * elem_b;
    assign p_aa = elem_a * elem_a;
    assign p_bb = elem_b * elem_b;
    assign s_ab = {1'b0, dot_reg} + {{(AW+1-2*EW){1'b0}}, p_ab};
    assign s_aa = {1'b0, sa_reg}  + {{(AW+1-2*EW){1'b0}}, p_aa};
    assign s_bb = {1'b0, sb_reg}  + {{(AW+1-2*EW){1'b0}}, p_bb};

    always_comb
    begin
        dot_next = dot_reg;
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        if (cmd.clear)
        begin
            dot_next = '0;
            sa_next  = '0;
            sb_next  = '0;
        end
        else if (cmd.accum && nz)
        begin
            dot_next = s_ab[AW] ? scs_pkg::ACC_MAX : s_ab[AW-1:0];
            sa_next  = s_aa[AW] ? scs_pkg::ACC_MAX : s_aa[AW-1:0];
            sb_next  = s_bb[AW] ? scs_pkg::ACC_MAX : s_bb[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
        end
    end

    // ---------------- search engine ----------------
    logic [3:0]     ph_reg;
    logic [2:0]     pc_reg;        // partial-product counter
    logic [3:0]     bit_reg;       // 15 = the exact-one test, 14..0 = bits
    logic [AW-1:0]  x_reg, y_reg;
    logic [AW-1:0]  sa_hold, sb_hold;
    logic [CW-1:0]  rhs_reg;       // 2^30 * dot^2
    logic [PW-1:0]  prod_reg;      // sa*sb
    logic [CW-1:0]  acc_reg;       // running product
    logic [31:0]    t2_reg;        // t*t (or 2^30)
    logic [scs_pkg::QBITS-1:0] q_reg;
    logic           one_reg;
    logic           zero_reg;
    logic           drain_reg;
    logic           cmp_le;

    // shared 32x32 multiplier
    logic [31:0] m_a, m_b;
    logic [63:0] m_p;
    logic [63:0] m_p_reg;
    logic [6:0]  sh_reg;           // shift of registered partial
    logic        mv_reg;           // partial valid
    assign m_p = m_a * m_b;

    logic [15:0] t_val;
    assign t_val = {1'b0, q_reg} | (16'd1 << bit_reg);

    // operand selection: 48-bit values cut into 24-bit halves (x,y) / prod into
    // three 32-bit words times t2
    always_comb
    begin
        m_a = '0;
        m_b = '0;
        unique case (ph_reg) inside
            PH_SQ, PH_PR:
            begin
                m_a = {8'd0, pc_reg[1] ? x_reg[47:24] : x_reg[23:0]};
                m_b = {8'd0, pc_reg[0] ? y_reg[47:24] : y_reg[23:0]};
            end
            PH_TT:
            begin
                m_a = {16'd0, t_val};
                m_b = {16'd0, t_val};
            end
            PH_PT:
            begin
                case (pc_reg[1:0])
                    2'd0:    m_a = prod_reg[31:0];
                    2'd1:    m_a = prod_reg[63:32];
                    default: m_a = prod_reg[95:64];
                endcase
                m_b = t2_reg;
            end
            default: ;
        endcase
    end

    logic [6:0] sh_sel;
    always_comb
    begin
        sh_sel = '0;
        if (ph_reg == PH_SQ || ph_reg == PH_PR)
            sh_sel = 7'd24 * {5'd0, pc_reg[1:0] == 2'd3 ? 2'd2 :
                     ((pc_reg[1:0] == 2'd0) ? 2'd0 : 2'd1)};
        else if (ph_reg == PH_PT)
            sh_sel = 7'd32 * {5'd0, pc_reg[1:0]};
    end

    logic [CW-1:0] acc_sum;
    assign acc_sum = acc_reg + ({64'd0, m_p_reg} << sh_reg);

    logic pc_last;
    assign pc_last = (ph_reg == PH_PT) ? (pc_reg == 3'd2) : (pc_reg == 3'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_IDLE;
            pc_reg    <= '0;
            bit_reg   <= '0;
            mv_reg    <= 1'b0;
            q_reg     <= '0;
            one_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            acc_reg   <= '0;
            m_p_reg   <= '0;
            sh_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            sa_hold   <= '0;
            sb_hold   <= '0;
            rhs_reg   <= '0;
            prod_reg  <= '0;
            t2_reg    <= '0;
            drain_reg <= 1'b0;
            cmp_le    <= 1'b0;
        end
        else
        begin
            if (mv_reg)
                acc_reg <= acc_sum;
            m_p_reg <= m_p;
            sh_reg  <= sh_sel;
            mv_reg  <= 1'b0;
            if (cmd.start)
            begin
                zero_reg <= (dot_reg == '0);
                acc_reg  <= '0;
                pc_reg   <= '0;
                bit_reg  <= 4'd15;
                q_reg    <= '0;
                one_reg  <= 1'b0;
                ph_reg   <= PH_SQ;
                x_reg    <= dot_reg;
                y_reg    <= dot_reg;
                sa_hold  <= sa_reg;
                sb_hold  <= sb_reg;
            end
            else if (cmd.step)
            begin
                unique case (ph_reg) inside
                    PH_SQ, PH_PR, PH_PT:
                    begin
                        if (pc_reg[2] == 1'b0 && !(pc_last && drain_reg))
                        begin
                            mv_reg <= 1'b1;
                            if (pc_last)
                                drain_reg <= 1'b1;
                            else
                                pc_reg <= pc_reg + 3'd1;
                        end
                        else if (drain_reg && !mv_reg)
                        begin
                            drain_reg <= 1'b0;
                            pc_reg    <= '0;
                            acc_reg   <= '0;
                            if (ph_reg == PH_SQ)
                            begin
                                rhs_reg <= acc_reg << 30;
                                x_reg   <= sa_hold;
                                y_reg   <= sb_hold;
                                ph_reg  <= PH_PR;
                            end
                            else if (ph_reg == PH_PR)
                            begin
                                prod_reg <= acc_reg[PW-1:0];
                                t2_reg   <= 32'h4000_0000;
                                ph_reg   <= PH_PT;
                            end
                            else
                            begin
                                ph_reg <= PH_CMP;
                                cmp_le <= (acc_reg <= rhs_reg);
                            end
                        end
                    end
                    PH_TT:
                    begin
                        t2_reg <= m_p[31:0];
                        ph_reg <= PH_PT;
                    end
                    PH_CMP:
                    begin
                        if (bit_reg == 4'd15)
                        begin
                            one_reg <= cmp_le;
                            if (cmp_le)
                                ph_reg <= PH_DONE;
                            else
                            begin
                                bit_reg <= 4'd14;
                                ph_reg  <= PH_TT;
                            end
                        end
                        else
                        begin
                            if (cmp_le)
                                q_reg <= t_val[scs_pkg::QBITS-1:0];
                            if (bit_reg == 4'd0)
                                ph_reg <= PH_DONE;
                            else
                            begin
                                bit_reg <= bit_reg - 4'd1;
                                ph_reg  <= PH_TT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.load_out)
                ph_reg <= PH_IDLE;
        end
    end

    assign stat.search_done = (ph_reg == PH_DONE);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_val  <= '0;
            ovl_flag <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            if (zero_reg)
            begin
                cos_val  <= '0;
                ovl_flag <= 1'b1;
            end
            else
            begin
                cos_val  <= one_reg ? scs_pkg::COS_ONE : {1'b0, q_reg};
                ovl_flag <= 1'b0;
            end
        end
    end

endmodule

### src/scs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_ctrl: controller for sparse cosine similarity
// Sequences accumulation, the result search and the output handshake.
// ----------------------------------------------------------------------------
module scs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           in_last,
    output logic           out_valid,
    input  logic           out_stall,
    output scs_pkg::cmd_t  cmd,
    input  scs_pkg::stat_t stat
);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       take;

    // out register frees when taken; no new item accepted while a result
    // is being computed
    assign in_stall  = (state_reg != ST_ACC) || (ov_reg && out_stall && in_last);
    assign take      = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        unique case (state_reg)
            ST_ACC:
            begin
                if (take)
                begin
                    cmd.accum = 1'b1;
                    if (in_last)
                        state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.start  = 1'b1;
                cmd.clear  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.step = 1'b1;
                if (stat.search_done && !(ov_reg && out_stall))
                begin
                    cmd.step     = 1'b0;
                    cmd.load_out = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accum_only_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> state_reg == ST_ACC) else $error("accumulate outside ACC");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid) else $error("result not shown");
    a_last_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last) |=> state_reg == ST_CALC) else $error("last not handled");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(ov_reg && out_stall)) else $error("result overwritten");
`endif

endmodule

### src/sparse_cosine_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_cosine_similarity: streamed cosine similarity of two vectors
// Use: push element pairs (elem_a, elem_b) on the input channel, one per
// transaction, with last high on the final pair. Pairs in which either value
// is zero do not contribute. Sums are exact 48-bit saturating integers.
// Each last transaction yields one output transaction: cosine in unsigned
// Q1.15 (32768 = 1.0), truncated, and no_overlap when the dot product was 0.
// Throughput: one pair per cycle while accumulating. After a last pair the
// input stalls while the root/divide search runs on one shared 32x32
// multiplier: a setup step, then dot^2, sa*sb and the exact-one test, then a
// step for each of the 15 result bits, then the load into the output register;
// the bit steps are skipped when the result is exactly one. The next pair can
// be taken in the cycle after the load at the earliest.
// The result then sits in the output register until taken; when the receiver
// stalls, the block keeps accepting pairs for the next vectors and holds only
// the next last pair, and a finished search waits in its load cycle.
// Reset clears the accumulators and drops any result.
// ----------------------------------------------------------------------------
module sparse_cosine_similarity #(
    parameter int MAX_ELEMENTS = scs_pkg::MAX_ELEMENTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [scs_pkg::ELEM_W-1:0]  elem_a,
    input  logic [scs_pkg::ELEM_W-1:0]  elem_b,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [scs_pkg::COS_W-1:0]   cosine,
    output logic                        no_overlap
);

    scs_pkg::cmd_t  cmd;
    scs_pkg::stat_t stat;

    // Controller: handshakes and sequencing.
    scs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_last   (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: accumulators, search engine and output register.
    scs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .elem_a   (elem_a),
        .elem_b   (elem_b),
        .cos_val  (cosine),
        .ovl_flag (no_overlap)
    );

`ifndef NO_ASSERTIONS
    a_max_range: assert property (@(posedge clk)
        MAX_ELEMENTS >= 1 && MAX_ELEMENTS <= scs_pkg::MAX_ELEMENTS)
        else $error("MAX_ELEMENTS out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(cosine))
        else $error("output changed while stalled");
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_overlap) |-> cosine == '0)
        else $error("no_overlap with nonzero cosine");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sparse_cosine_similarity
// Streams element-pair vectors (directed table, then random vectors) through
// the block under varying idle and stall pressure, predicts each cosine with
// exact wide integer arithmetic and compares every output transaction.
// ----------------------------------------------------------------------------
module tb;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  N_RANDOM     = 600;

    typedef struct {
        logic [scs_pkg::ELEM_W-1:0] a;
        logic [scs_pkg::ELEM_W-1:0] b;
        logic              lst;
        bit                typed;   // expected result given in the table
        logic [scs_pkg::COS_W-1:0]  cos_exp;
        logic              nov_exp;
    } pair_t;

    typedef struct {
        logic [scs_pkg::COS_W-1:0] cos;
        logic             nov;
    } sim_t;

    // directed table row: a pair repeated rep times, last only on the final copy
    typedef struct {
        int               a;
        int               b;
        bit               lst;
        int               rep;
        bit               typed;
        int               cos_exp;
        bit               nov_exp;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [scs_pkg::ELEM_W-1:0] elem_a = '0;
    logic [scs_pkg::ELEM_W-1:0] elem_b = '0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [scs_pkg::COS_W-1:0]  cosine;
    logic              no_overlap;

    pair_t             pairs[$];
    sim_t              pending_sims[$];
    pair_t             cur;
    int                next_idx = 0;
    int                n_directed = 0;
    int                n_taken = 0;
    bit                took_in = 1'b0;
    int                idle_in = 0;
    int                stall_out = 0;
    int                cycles = 0;
    int                errors = 0;
    int                n_results = 0;
    int                n_vectors = 0;
    logic [scs_pkg::ACC_W-1:0]  dot_acc = '0;
    logic [scs_pkg::ACC_W-1:0]  sq_a_acc = '0;
    logic [scs_pkg::ACC_W-1:0]  sq_b_acc = '0;

    sparse_cosine_similarity dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .elem_a(elem_a), .elem_b(elem_b), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .cosine(cosine), .no_overlap(no_overlap)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [scs_pkg::ACC_W-1:0] sat_add(
        logic [scs_pkg::ACC_W-1:0] acc, logic [scs_pkg::ACC_W-1:0] v);
        logic [scs_pkg::ACC_W:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[scs_pkg::ACC_W] ? scs_pkg::ACC_MAX : s[scs_pkg::ACC_W-1:0];
    endfunction

    // floor(32768 * dot / sqrt(sa * sb)), clamped to 1.0, by exact bit search
    function automatic logic [scs_pkg::COS_W-1:0] q15_ratio(
        logic [scs_pkg::ACC_W-1:0] d,
        logic [scs_pkg::ACC_W-1:0] sa,
        logic [scs_pkg::ACC_W-1:0] sb);
        logic [199:0] prod;
        logic [199:0] rhs;
        logic [199:0] t;
        logic [15:0]  q;
        q    = '0;
        prod = 200'(sa) * 200'(sb);
        rhs  = (200'(d) * 200'(d)) << 30;
        if ((prod << 30) <= rhs)
            return scs_pkg::COS_ONE;
        for (int bitn = 14; bitn >= 0; bitn--)
        begin
            t = 200'(q | (16'd1 << bitn));
            if (prod * t * t <= rhs)
                q = q | (16'd1 << bitn);
        end
        return q;
    endfunction

    // Advance the accumulator model by one pair; return 1 when a result is due.
    function automatic bit similarity_step(pair_t p, output sim_t r);
        r.cos = '0;
        r.nov = 1'b0;
        if (p.a != 0 && p.b != 0)
        begin
            dot_acc  = sat_add(dot_acc,  48'(p.a) * 48'(p.b));
            sq_a_acc = sat_add(sq_a_acc, 48'(p.a) * 48'(p.a));
            sq_b_acc = sat_add(sq_b_acc, 48'(p.b) * 48'(p.b));
        end
        if (!p.lst)
            return 1'b0;
        if (dot_acc == 0)
            r.nov = 1'b1;
        else
            r.cos = q15_ratio(dot_acc, sq_a_acc, sq_b_acc);
        dot_acc  = '0;
        sq_a_acc = '0;
        sq_b_acc = '0;
        return 1'b1;
    endfunction

    function automatic logic [scs_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(7)) inside
            0, 1:    return '0;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(1, 3));
            4, 5:    return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Monitor: note accepted input transactions, predict, check outputs.
    always @(posedge clk)
    begin
        sim_t r;
        sim_t e;
        took_in = 1'b0;
        if (rst_n)
        begin
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycles, pending_sims.size());
                $display("tb: errors");
                $finish;
            end
            if (in_valid && !in_stall)
            begin
                took_in = 1'b1;
                n_taken++;
                if (similarity_step(cur, r))
                begin
                    // a typed row overrides the predictor for the expectation
                    if (cur.typed)
                    begin
                        r.cos = cur.cos_exp;
                        r.nov = cur.nov_exp;
                    end
                    pending_sims.push_back(r);
                end
            end
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (pending_sims.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result cosine=%0d no_overlap=%0b",
                                 cosine, no_overlap);
                end
                else
                begin
                    e = pending_sims.pop_front();
                    if (cosine !== e.cos || no_overlap !== e.nov)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d: expected cosine=%0d no_overlap=%0b, got %0d %0b",
                                     n_results, e.cos, e.nov, cosine, no_overlap);
                    end
                end
            end
        end
    end

    // Driver: change inputs at the falling edge, hold a stalled transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (next_idx >= n_directed)
            begin
                case (((next_idx - n_directed) * 4) / (pairs.size() - n_directed + 1))
                    0:       begin idle_in = 80; stall_out = 0;  end
                    1:       begin idle_in = 0;  stall_out = 80; end
                    2:       begin idle_in = 15; stall_out = 15; end
                    default: begin idle_in = 0;  stall_out = 0;  end
                endcase
            end
            out_stall <= ($urandom_range(99) < stall_out);
            if (!in_valid || took_in)
            begin
                if (next_idx < pairs.size() && $urandom_range(99) >= idle_in)
                begin
                    cur = pairs[next_idx];
                    next_idx++;
                    elem_a   <= cur.a;
                    elem_b   <= cur.b;
                    last     <= cur.lst;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    initial
    begin
        row_t  rows[$];
        pair_t p;
        int    len;
        int    wait_cycles;

        // directed table: extremes, skipped pairs, no overlap
        rows = '{
            '{0, 0, 1, 1, 1, 0, 1},              // empty vector right after reset
            '{5, 0, 0, 1, 0, 0, 0},
            '{0, 7, 1, 1, 1, 0, 1},              // only skipped pairs: no overlap
            '{1, 2, 1, 1, 1, 32768, 0},          // single dimension: exactly one
            '{3, 4, 0, 1, 0, 0, 0},
            '{0, 9, 0, 1, 0, 0, 0},
            '{3, 4, 1, 1, 1, 32768, 0},          // parallel vectors
            '{65535, 65535, 1, 1, 1, 32768, 0},  // full scale
            '{1, 65535, 0, 1, 0, 0, 0},
            '{65535, 1, 1, 1, 0, 0, 0},          // nearly orthogonal
            '{2, 1, 0, 1, 0, 0, 0},
            '{1, 2, 1, 1, 0, 0, 0},
            '{65535, 0, 0, 1, 0, 0, 0},
            '{1, 1, 0, 1, 0, 0, 0},
            '{0, 65535, 1, 1, 0, 0, 0},
            '{65535, 65535, 1, 4, 1, 32768, 0},  // repeated full scale
            '{0, 0, 1, 1, 1, 0, 1}               // accumulators cleared afterwards
        };
        foreach (rows[i])
        begin
            for (int k = 0; k < rows[i].rep; k++)
            begin
                p.a       = 16'(rows[i].a);
                p.b       = 16'(rows[i].b);
                p.lst     = rows[i].lst && (k == rows[i].rep - 1);
                p.typed   = rows[i].typed && p.lst;
                p.cos_exp = 16'(rows[i].cos_exp);
                p.nov_exp = rows[i].nov_exp;
                pairs.push_back(p);
            end
            n_vectors += rows[i].lst;
        end
        n_directed = pairs.size();

        // random vectors, mostly short, a few longer
        while (pairs.size() - n_directed < N_RANDOM)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                p.a     = rand_elem();
                p.b     = rand_elem();
                p.lst   = (k == len - 1);
                p.typed = 1'b0;
                pairs.push_back(p);
            end
            n_vectors++;
        end

        // hold reset, then release at a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_taken == pairs.size());
        while (pending_sims.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 400)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("covered %0d pairs in %0d vectors (%0d directed pairs), %0d results checked",
                 pairs.size(), n_vectors, n_directed, n_results);
        $display("phases: free running, sender idle, receiver stall, mixed; %0d mismatches",
                 errors);
        if (errors == 0 && pending_sims.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
